>>> sv/tqmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqmg_pkg
// Shared types, codes and constants of the tiled quad mesh generator.
// ----------------------------------------------------------------------------
package tqmg_pkg;

   localparam int LEN_W      = 24;
   localparam int TEX_W      = 17;
   localparam int OUT_TEX_W  = 18;
   localparam int IDX_W      = 18;
   localparam int CNT_W      = 25;
   localparam int FRAC_W     = 16;
   localparam int DIV_STEPS  = LEN_W + FRAC_W;
   localparam int CSR_IDX_W  = 4;
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_MAX_ROWS    = 256;

   localparam logic [TEX_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_TRI    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_WORLD_W = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WORLD_H = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_W  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_H  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ORG_U   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ORG_V   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPAN_U  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPAN_V  = 4'd7;

   typedef struct packed {
      logic [DIV_STEPS-1:0] quot;
      logic                 rem_nz;
   } div_res_type;

   typedef struct packed {
      logic [LEN_W-1:0]  world_w;
      logic [LEN_W-1:0]  world_h;
      logic [LEN_W-1:0]  tile_w;
      logic [LEN_W-1:0]  tile_h;
      logic [TEX_W-1:0]  org_u;
      logic [TEX_W-1:0]  org_v;
      logic [TEX_W-1:0]  span_u;
      logic [TEX_W-1:0]  span_v;
      logic [CNT_W-1:0]  cols;
      logic [CNT_W-1:0]  rows;
      logic [FRAC_W-1:0] frac_x;
      logic [FRAC_W-1:0] frac_y;
      logic              part_x;
      logic              part_y;
   } geom_type;

   typedef struct packed {
      logic                 err;
      logic [IDX_W-1:0]     base;
      logic [IDX_W-1:0]     vx;
      logic [LEN_W-1:0]     pos_x0;
      logic [LEN_W-1:0]     pos_x1;
      logic [LEN_W-1:0]     pos_y0;
      logic [LEN_W-1:0]     pos_y1;
      logic [OUT_TEX_W-1:0] tu0;
      logic [OUT_TEX_W-1:0] tu1;
      logic [OUT_TEX_W-1:0] tv0;
      logic [OUT_TEX_W-1:0] tv1;
   } tile_type;

endpackage

>>> sv/tiled_quad_mesh_generator.sv
`timescale 1ns / 1ps
// An accepted tile beat passes the tqmg_pipe stages and the tqmg_emit tile register
// before its first result beat. A tile gives ten result beats, error tiles one each,
// at one per cycle while rsp_ready is high. After reset and each register write,
// req_ready stays low while column and row dividers start and run. csr_ready is high.
// Reset is synchronous, active high, and restores the register defaults.
// ----------------------------------------------------------------------------
// tiled_quad_mesh_generator
// Emits corner vertices and triangle index words for one grid tile per beat.
// ----------------------------------------------------------------------------
module tiled_quad_mesh_generator #(
   parameter int MAX_COLUMNS = tqmg_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tqmg_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tqmg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tqmg_pkg::LEN_W-1:0]            csr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_tile_col,
   input  logic [7:0]                            req_tile_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic [tqmg_pkg::IDX_W-1:0]            rsp_index_value,
   output logic signed [tqmg_pkg::LEN_W-1:0]     rsp_pos_x,
   output logic signed [tqmg_pkg::LEN_W-1:0]     rsp_pos_y,
   output logic [tqmg_pkg::OUT_TEX_W-1:0]        rsp_tex_u,
   output logic [tqmg_pkg::OUT_TEX_W-1:0]        rsp_tex_v,
   output logic                                  rsp_last
);

   logic [tqmg_pkg::LEN_W-1:0] ww_ff, wh_ff, tw_ff, th_ff;
   logic [tqmg_pkg::TEX_W-1:0] ou_ff, ov_ff, su_ff, sv_ff;
   logic                       dirty_ff;
   logic                       busy_x, busy_y, start, busy;
   logic                       csr_wr;
   tqmg_pkg::div_res_type      dx_res, dy_res;
   tqmg_pkg::geom_type         geom;
   logic                       pipe_valid, pipe_ready, pipe_in_ready;
   tqmg_pkg::tile_type         pipe_tile;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign start     = dirty_ff && !busy_x && !busy_y;
   assign busy      = dirty_ff || busy_x || busy_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff    <= 24'd256;
         wh_ff    <= 24'd256;
         tw_ff    <= 24'd256;
         th_ff    <= 24'd256;
         ou_ff    <= '0;
         ov_ff    <= '0;
         su_ff    <= tqmg_pkg::ONE_Q16;
         sv_ff    <= tqmg_pkg::ONE_Q16;
         dirty_ff <= 1'b1;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               tqmg_pkg::REG_WORLD_W: ww_ff <= csr_data;
               tqmg_pkg::REG_WORLD_H: wh_ff <= csr_data;
               tqmg_pkg::REG_TILE_W:  tw_ff <= csr_data;
               tqmg_pkg::REG_TILE_H:  th_ff <= csr_data;
               tqmg_pkg::REG_ORG_U:   ou_ff <= csr_data[tqmg_pkg::TEX_W-1:0];
               tqmg_pkg::REG_ORG_V:   ov_ff <= csr_data[tqmg_pkg::TEX_W-1:0];
               tqmg_pkg::REG_SPAN_U:  su_ff <= csr_data[tqmg_pkg::TEX_W-1:0];
               tqmg_pkg::REG_SPAN_V:  sv_ff <= csr_data[tqmg_pkg::TEX_W-1:0];
               default: ;
            endcase
         end
         // Any write restarts the grid divisions, even one to an unused index.
         if (csr_wr) begin
            dirty_ff <= 1'b1;
         end else if (start) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   tqmg_div u_div_x (
      .clock (clock), .reset (reset), .start (start),
      .num (ww_ff), .den (tw_ff), .busy (busy_x), .res (dx_res)
   );

   tqmg_div u_div_y (
      .clock (clock), .reset (reset), .start (start),
      .num (wh_ff), .den (th_ff), .busy (busy_y), .res (dy_res)
   );

   always_comb begin
      geom.world_w = ww_ff;
      geom.world_h = wh_ff;
      geom.tile_w  = tw_ff;
      geom.tile_h  = th_ff;
      geom.org_u   = ou_ff;
      geom.org_v   = ov_ff;
      geom.span_u  = su_ff;
      geom.span_v  = sv_ff;
      geom.cols    = {1'b0, dx_res.quot[tqmg_pkg::DIV_STEPS-1:tqmg_pkg::FRAC_W]}
                   + tqmg_pkg::CNT_W'(dx_res.rem_nz);
      geom.rows    = {1'b0, dy_res.quot[tqmg_pkg::DIV_STEPS-1:tqmg_pkg::FRAC_W]}
                   + tqmg_pkg::CNT_W'(dy_res.rem_nz);
      geom.frac_x  = dx_res.quot[tqmg_pkg::FRAC_W-1:0];
      geom.frac_y  = dy_res.quot[tqmg_pkg::FRAC_W-1:0];
      geom.part_x  = dx_res.rem_nz;
      geom.part_y  = dy_res.rem_nz;
   end

   assign req_ready = pipe_in_ready && !busy;

   tqmg_pipe #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .in_valid  (req_valid && !busy),
      .in_ready  (pipe_in_ready),
      .in_col    (req_tile_col),
      .in_row    (req_tile_row),
      .out_valid (pipe_valid),
      .out_ready (pipe_ready),
      .out_tile  (pipe_tile)
   );

   tqmg_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pipe_valid),
      .in_ready        (pipe_ready),
      .in_tile         (pipe_tile),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_index_value (rsp_index_value),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_last        (rsp_last)
   );

endmodule

>>> sv/tqmg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqmg_div
// Radix-2 restoring divider: (num << 16) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tqmg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tqmg_pkg::LEN_W-1:0]  num,
   input  logic [tqmg_pkg::LEN_W-1:0]  den,
   output logic                        busy,
   output tqmg_pkg::div_res_type       res
);

   logic [5:0]                      cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic [tqmg_pkg::LEN_W-1:0]      rem_ff, rem_in;
   logic [tqmg_pkg::DIV_STEPS-1:0]  dvd_ff, dvd_in;
   logic                            nz_ff, nz_in;
   logic [tqmg_pkg::LEN_W:0]        trial;
   logic                            ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[tqmg_pkg::DIV_STEPS-1]};
      ge      = trial >= {1'b0, den};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      nz_in   = nz_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         rem_in  = '0;
         dvd_in  = {num, {tqmg_pkg::FRAC_W{1'b0}}};
      end else if (busy_ff) begin
         rem_in = ge ? tqmg_pkg::LEN_W'(trial - {1'b0, den}) : trial[tqmg_pkg::LEN_W-1:0];
         dvd_in = {dvd_ff[tqmg_pkg::DIV_STEPS-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         // The remainder after the integer bits tells whether the last tile is partial.
         if (cnt_ff == 6'(tqmg_pkg::LEN_W - 1)) begin
            nz_in = rem_in != '0;
         end
         if (cnt_ff == 6'(tqmg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      nz_ff  <= nz_in;
   end

   assign busy       = busy_ff;
   assign res.quot   = dvd_ff;
   assign res.rem_nz = nz_ff;

endmodule

>>> sv/tqmg_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqmg_pipe
// Three-stage tile datapath: corner products, clipping and texture products,
// then saturation and texture offset.
// ----------------------------------------------------------------------------
module tqmg_pipe #(
   parameter int MAX_COLUMNS = tqmg_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tqmg_pkg::DEF_MAX_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tqmg_pkg::geom_type     geom,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_col,
   input  logic [7:0]             in_row,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tqmg_pkg::tile_type     out_tile
);

   localparam int PW = tqmg_pkg::LEN_W + 9;
   localparam int MW = 2 * tqmg_pkg::TEX_W;

   logic move;

   // Stage 1
   logic                            v1_ff;
   logic                            err1_ff, err1_in;
   logic [PW-1:0]                   tx0_ff, tx1_ff, ty0_ff, ty1_ff;
   logic [tqmg_pkg::TEX_W-1:0]      ru1_ff, ru1_in, rv1_ff, rv1_in;
   logic [tqmg_pkg::IDX_W-1:0]      base1_ff, base1_in, vx1_ff;
   logic                            last_c, last_r;
   // Stage 2
   logic                            v2_ff, err2_ff;
   logic signed [tqmg_pkg::LEN_W+1:0] px0_ff, px1_ff, py0_ff, py1_ff;
   logic signed [tqmg_pkg::LEN_W+1:0] px0_in, px1_in, py0_in, py1_in;
   logic [MW-1:0]                   pu_ff, pv_ff;
   logic [tqmg_pkg::IDX_W-1:0]      base2_ff, vx2_ff;
   logic [tqmg_pkg::LEN_W-1:0]      half_lo, half_hi;
   // Stage 3
   logic                            v3_ff;
   tqmg_pkg::tile_type              t3_ff, t3_in;

   function automatic logic [tqmg_pkg::LEN_W-1:0] clip_min(
      input logic [PW-1:0] t, input logic [tqmg_pkg::LEN_W-1:0] lim);
      clip_min = (t < PW'(lim)) ? t[tqmg_pkg::LEN_W-1:0] : lim;
   endfunction

   function automatic logic [tqmg_pkg::LEN_W-1:0] sat(
      input logic signed [tqmg_pkg::LEN_W+1:0] x);
      logic [tqmg_pkg::LEN_W-1:0] r;
      if (x > 26'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (x < -26'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = x[tqmg_pkg::LEN_W-1:0];
      end
      sat = r;
   endfunction

   // The whole pipeline advances together whenever the last stage is free or drains.
   assign move     = !v3_ff || out_ready;
   assign in_ready = move;

   always_comb begin
      err1_in = (geom.tile_w == '0) || (geom.tile_h == '0)
             || (geom.cols > tqmg_pkg::CNT_W'(MAX_COLUMNS))
             || (geom.rows > tqmg_pkg::CNT_W'(MAX_ROWS))
             || ({17'd0, in_col} >= geom.cols) || ({17'd0, in_row} >= geom.rows);
      last_c  = ({17'd0, in_col} == geom.cols - 25'd1) && geom.part_x;
      last_r  = ({17'd0, in_row} == geom.rows - 25'd1) && geom.part_y;
      ru1_in  = last_c ? {1'b0, geom.frac_x} : tqmg_pkg::ONE_Q16;
      rv1_in  = last_r ? tqmg_pkg::TEX_W'(tqmg_pkg::ONE_Q16 - {1'b0, geom.frac_y}) : '0;
      base1_in = tqmg_pkg::IDX_W'({in_row, 2'b00} * geom.cols)
               + tqmg_pkg::IDX_W'({in_col, 1'b0});
   end

   always_comb begin
      half_lo = {1'b0, geom.world_w[tqmg_pkg::LEN_W-1:1]};
      half_hi = geom.world_h - {1'b0, geom.world_h[tqmg_pkg::LEN_W-1:1]};
      px0_in = $signed({2'b00, clip_min(tx0_ff, geom.world_w)}) - $signed({2'b00, half_lo});
      px1_in = $signed({2'b00, clip_min(tx1_ff, geom.world_w)}) - $signed({2'b00, half_lo});
      py0_in = $signed({2'b00, half_hi}) - $signed({2'b00, clip_min(ty0_ff, geom.world_h)});
      py1_in = $signed({2'b00, half_hi}) - $signed({2'b00, clip_min(ty1_ff, geom.world_h)});
   end

   always_comb begin
      t3_in.err    = err2_ff;
      t3_in.base   = base2_ff;
      t3_in.vx     = vx2_ff;
      t3_in.pos_x0 = sat(px0_ff);
      t3_in.pos_x1 = sat(px1_ff);
      t3_in.pos_y0 = sat(py0_ff);
      t3_in.pos_y1 = sat(py1_ff);
      t3_in.tu0    = {1'b0, geom.org_u};
      t3_in.tu1    = pu_ff[MW-1:16] + {1'b0, geom.org_u};
      t3_in.tv0    = {1'b0, geom.span_v} + {1'b0, geom.org_v};
      t3_in.tv1    = pv_ff[MW-1:16] + {1'b0, geom.org_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (move) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (move) begin
         err1_ff  <= err1_in;
         tx0_ff   <= {1'b0, in_col} * geom.tile_w;
         tx1_ff   <= ({1'b0, in_col} + 9'd1) * geom.tile_w;
         ty0_ff   <= {1'b0, in_row} * geom.tile_h;
         ty1_ff   <= ({1'b0, in_row} + 9'd1) * geom.tile_h;
         ru1_ff   <= ru1_in;
         rv1_ff   <= rv1_in;
         base1_ff <= base1_in;
         vx1_ff   <= tqmg_pkg::IDX_W'({geom.cols, 1'b0});
         err2_ff  <= err1_ff;
         px0_ff   <= px0_in;
         px1_ff   <= px1_in;
         py0_ff   <= py0_in;
         py1_ff   <= py1_in;
         pu_ff    <= ru1_ff * geom.span_u;
         pv_ff    <= rv1_ff * geom.span_v;
         base2_ff <= base1_ff;
         vx2_ff   <= vx1_ff;
         t3_ff    <= t3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_tile  = t3_ff;

endmodule

>>> sv/tqmg_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqmg_emit
// Holds one finished tile and sends its ten result beats, or one error beat.
// ----------------------------------------------------------------------------
module tqmg_emit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  tqmg_pkg::tile_type                    in_tile,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic [tqmg_pkg::IDX_W-1:0]            rsp_index_value,
   output logic signed [tqmg_pkg::LEN_W-1:0]     rsp_pos_x,
   output logic signed [tqmg_pkg::LEN_W-1:0]     rsp_pos_y,
   output logic [tqmg_pkg::OUT_TEX_W-1:0]        rsp_tex_u,
   output logic [tqmg_pkg::OUT_TEX_W-1:0]        rsp_tex_v,
   output logic                                  rsp_last
);

   logic               valid_ff;
   logic [3:0]         cnt_ff;
   tqmg_pkg::tile_type t_ff;
   logic               is_last;
   logic               load;

   assign is_last  = t_ff.err || (cnt_ff == 4'd9);
   assign in_ready = !valid_ff || (rsp_ready && is_last);
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         cnt_ff   <= '0;
      end else if (valid_ff && rsp_ready) begin
         valid_ff <= !is_last;
         cnt_ff   <= cnt_ff + 4'd1;
      end
      if (load) begin
         t_ff <= in_tile;
      end
   end

   always_comb begin
      rsp_kind        = tqmg_pkg::KIND_TRI;
      rsp_index_value = t_ff.base;
      rsp_pos_x       = '0;
      rsp_pos_y       = '0;
      rsp_tex_u       = '0;
      rsp_tex_v       = '0;
      rsp_last        = 1'b0;
      if (t_ff.err) begin
         rsp_kind        = tqmg_pkg::KIND_ERROR;
         rsp_index_value = '0;
         rsp_last        = 1'b1;
      end else if (cnt_ff < 4'd4) begin
         // Corners go out row by row: low bit of the count is dx, next bit dy.
         rsp_kind        = tqmg_pkg::KIND_VERTEX;
         rsp_index_value = t_ff.base + (cnt_ff[1] ? t_ff.vx : '0)
                         + tqmg_pkg::IDX_W'(cnt_ff[0]);
         rsp_pos_x       = cnt_ff[0] ? t_ff.pos_x1 : t_ff.pos_x0;
         rsp_pos_y       = cnt_ff[1] ? t_ff.pos_y1 : t_ff.pos_y0;
         rsp_tex_u       = cnt_ff[0] ? t_ff.tu1 : t_ff.tu0;
         rsp_tex_v       = cnt_ff[1] ? t_ff.tv1 : t_ff.tv0;
      end else begin
         case (cnt_ff)
            4'd4:    rsp_index_value = t_ff.base;
            4'd5:    rsp_index_value = t_ff.base + 18'd1;
            4'd6:    rsp_index_value = t_ff.base + t_ff.vx;
            4'd7:    rsp_index_value = t_ff.base + 18'd1;
            4'd8:    rsp_index_value = t_ff.base + t_ff.vx + 18'd1;
            default: begin
               rsp_index_value = t_ff.base + t_ff.vx;
               rsp_last        = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid = valid_ff;

endmodule
